// ===== design/rotary_encoder_debounced_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rotary encoder decoder core
// Shared wrappers that give every concurrent check the same clocking, reset
// qualification and error report.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_DEBOUNCED_DECODER_CORE_ASSERT_SVH
`define ROTARY_ENCODER_DEBOUNCED_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define REDD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("redd assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define REDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("redd assertion failed");

`endif

// ===== design/redd_pkg.sv =====
// ----------------------------------------------------------------------------
// redd_pkg
// Types, event codes, register indexes and reset values shared by the rotary
// encoder decoder core and its interfaces.
// ----------------------------------------------------------------------------
package redd_pkg;

   localparam int unsigned DEBOUNCE_W  = 8;
   localparam int unsigned SETTLE_W    = 9;
   localparam int unsigned POSITION_W  = 32;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RESET   = 8'd10;
   localparam logic                  BUTTON_ENABLE_RESET = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_MS   = 1'b0,
      CSR_BUTTON_ENABLE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_NONE = 2'd0,
      ROT_CW   = 2'd1,
      ROT_CCW  = 2'd2
   } rot_event_type;

   typedef enum logic [1:0] {
      BTN_NONE    = 2'd0,
      BTN_PRESS   = 2'd1,
      BTN_RELEASE = 2'd2
   } btn_event_type;

   typedef struct packed {
      rot_event_type                 rotation_event;
      logic signed [POSITION_W-1:0]  position;
   } enc_result_type;

   typedef struct packed {
      btn_event_type button_event;
      logic          button_pressed;
   } btn_result_type;

endpackage

// ===== design/redd_if.sv =====
// ----------------------------------------------------------------------------
// redd_if
// Valid/ready channels of the rotary encoder decoder: one tick beat in, one
// result beat out.
// ----------------------------------------------------------------------------
interface redd_req_if;
   import redd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  clk_level;
   logic                  dt_level;
   logic                  button_level;
   logic [DEBOUNCE_W-1:0] elapsed_ms;

   modport source (output valid, clk_level, dt_level, button_level, elapsed_ms,
                   input ready);
   modport sink   (input valid, clk_level, dt_level, button_level, elapsed_ms,
                   output ready);
endinterface

interface redd_rsp_if;
   import redd_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [1:0]                   rotation_event;
   logic signed [POSITION_W-1:0] position;
   logic [1:0]                   button_event;
   logic                         button_pressed;

   modport source (output valid, rotation_event, position, button_event, button_pressed,
                   input ready);
   modport sink   (input valid, rotation_event, position, button_event, button_pressed,
                   output ready);
endinterface

// ===== design/redd_encoder.sv =====
// ----------------------------------------------------------------------------
// redd_encoder
// Debounces the CLK/DT pair and keeps the wrapping position count.
// ----------------------------------------------------------------------------
module redd_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              clk_level,
   input  logic                              dt_level,
   input  logic [redd_pkg::DEBOUNCE_W-1:0]   elapsed_ms,
   input  logic [redd_pkg::DEBOUNCE_W-1:0]   debounce_ms,
   output redd_pkg::enc_result_type          result
);
   import redd_pkg::*;

   logic                         acc_clk_ff, acc_clk_in;
   logic                         acc_dt_ff, acc_dt_in;
   logic [SETTLE_W-1:0]          settle_ff, settle_in;
   logic signed [POSITION_W-1:0] count_ff, count_in;

   logic                changed;
   logic [SETTLE_W-1:0] settle_sum;
   logic                settled;
   logic                step;
   rot_event_type       rot;

   always_comb begin
      changed    = (clk_level != acc_clk_ff) || (dt_level != acc_dt_ff);
      settle_sum = settle_ff + {1'b0, elapsed_ms};
      settled    = settle_sum >= {1'b0, debounce_ms};
      // A step is a debounced CLK rise that comes with a change of DT.
      step       = changed && settled && clk_level && !acc_clk_ff
                   && (dt_level != acc_dt_ff);

      acc_clk_in = acc_clk_ff;
      acc_dt_in  = acc_dt_ff;
      settle_in  = '0;
      count_in   = count_ff;
      rot        = ROT_NONE;

      if (changed && !settled) begin
         settle_in = settle_sum;
      end
      if (changed && settled) begin
         acc_clk_in = clk_level;
         acc_dt_in  = dt_level;
      end
      if (step) begin
         if (dt_level == acc_clk_ff) begin
            count_in = count_ff + 32'sd1;
            rot      = ROT_CW;
         end else begin
            count_in = count_ff - 32'sd1;
            rot      = ROT_CCW;
         end
      end

      result.rotation_event = rot;
      result.position       = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_clk_ff <= 1'b1;
         acc_dt_ff  <= 1'b1;
         settle_ff  <= '0;
         count_ff   <= '0;
      end else if (advance) begin
         acc_clk_ff <= acc_clk_in;
         acc_dt_ff  <= acc_dt_in;
         settle_ff  <= settle_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ===== design/redd_button.sv =====
// ----------------------------------------------------------------------------
// redd_button
// Debounces the active-low push button and reports press and release.
// ----------------------------------------------------------------------------
module redd_button (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              button_level,
   input  logic [redd_pkg::DEBOUNCE_W-1:0]   elapsed_ms,
   input  logic [redd_pkg::DEBOUNCE_W-1:0]   debounce_ms,
   input  logic                              button_enable,
   output redd_pkg::btn_result_type          result
);
   import redd_pkg::*;

   logic                acc_btn_ff, acc_btn_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   logic                changed;
   logic [SETTLE_W-1:0] settle_sum;
   logic                settled;

   always_comb begin
      changed    = button_level != acc_btn_ff;
      settle_sum = settle_ff + {1'b0, elapsed_ms};
      settled    = settle_sum >= {1'b0, debounce_ms};

      acc_btn_in            = acc_btn_ff;
      settle_in             = '0;
      result.button_event   = BTN_NONE;
      result.button_pressed = 1'b0;

      // With the button disabled the accepted level is frozen and nothing is reported.
      if (button_enable) begin
         if (changed && !settled) begin
            settle_in = settle_sum;
         end
         if (changed && settled) begin
            acc_btn_in          = button_level;
            result.button_event = button_level ? BTN_RELEASE : BTN_PRESS;
         end
         result.button_pressed = !acc_btn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_btn_ff <= 1'b1;
         settle_ff  <= '0;
      end else if (advance) begin
         acc_btn_ff <= acc_btn_in;
         settle_ff  <= settle_in;
      end
   end

endmodule

// ===== design/rotary_encoder_debounced_decoder_core.sv =====
// Result: each result beat is registered as its tick beat is accepted.
// Throughput: one tick beat per cycle; the result register lets a new tick enter
// in the same cycle that the previous result is taken, and it stalls only
// while an unread result is held back by the consumer.
// Reset: synchronous, clears the debounce state, the position and the result
// valid flag, and restores debounce_ms to 10 and button_enable to 1.
// ----------------------------------------------------------------------------
// rotary_encoder_debounced_decoder_core
// Debounced quadrature decoder with a push button, one result beat per tick.
// ----------------------------------------------------------------------------
`include "rotary_encoder_debounced_decoder_core_assert.svh"

module rotary_encoder_debounced_decoder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   redd_req_if.sink                             req_bus,
   redd_rsp_if.source                           rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [redd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [redd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import redd_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic                  button_enable_ff;

   logic                  req_fire;
   logic                  rsp_fire;
   enc_result_type        enc_res;
   btn_result_type        btn_res;

   logic                         rsp_valid_ff, rsp_valid_in;
   rot_event_type                rot_ff;
   logic signed [POSITION_W-1:0] position_ff;
   btn_event_type                bev_ff;
   logic                         pressed_ff;

   logic                         cw_fire;
   logic                         ccw_fire;
   logic                         quiet_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_MS_RESET;
         button_enable_ff <= BUTTON_ENABLE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_MS:   debounce_ff      <= csr_wdata[DEBOUNCE_W-1:0];
            CSR_BUTTON_ENABLE: button_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The result register takes a new beat whenever it is empty or being drained.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_valid_ff && rsp_bus.ready;

   redd_encoder u_encoder (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_fire),
      .clk_level   (req_bus.clk_level),
      .dt_level    (req_bus.dt_level),
      .elapsed_ms  (req_bus.elapsed_ms),
      .debounce_ms (debounce_ff),
      .result      (enc_res)
   );

   redd_button u_button (
      .clock         (clock),
      .reset         (reset),
      .advance       (req_fire),
      .button_level  (req_bus.button_level),
      .elapsed_ms    (req_bus.elapsed_ms),
      .debounce_ms   (debounce_ff),
      .button_enable (button_enable_ff),
      .result        (btn_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         position_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            position_ff <= enc_res.position;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rot_ff     <= enc_res.rotation_event;
         bev_ff     <= btn_res.button_event;
         pressed_ff <= btn_res.button_pressed;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.rotation_event = rot_ff;
   assign rsp_bus.position       = position_ff;
   assign rsp_bus.button_event   = bev_ff;
   assign rsp_bus.button_pressed = pressed_ff;

   assign cw_fire    = req_fire && (enc_res.rotation_event == ROT_CW);
   assign ccw_fire   = req_fire && (enc_res.rotation_event == ROT_CCW);
   assign quiet_fire = req_fire && !button_enable_ff;

   `REDD_ASSERT_NEXT(a_fire_loads_result, clock, reset, req_fire, rsp_valid_ff)
   `REDD_ASSERT_NEXT(a_cw_step, clock, reset, cw_fire, position_ff == $past(position_ff) + 32'sd1)
   `REDD_ASSERT_NEXT(a_ccw_step, clock, reset, ccw_fire, position_ff == $past(position_ff) - 32'sd1)
   `REDD_ASSERT_NEXT(a_off_quiet, clock, reset, quiet_fire, !pressed_ff && (bev_ff == BTN_NONE))

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the debounced rotary encoder decoder. A directed
// table walks the settle thresholds, both step directions, button press and
// release, zero debounce, position wrap below zero and the disabled button.
// Random detent sequences with bounce, noise and broken sequences follow,
// over several debounce and button settings, with random gaps and stalls on
// both channels. Every result beat is checked against a cycle-free decoder
// model kept in this module, or against the table's expected result for typed rows.
// ----------------------------------------------------------------------------
module tb_top;
   import redd_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 1000;
   localparam int unsigned PHASE_TICKS  = 215;
   localparam int unsigned PHASE_COUNT  = 8;
   localparam int unsigned DIRECTED_LEN = 29;

   typedef struct packed {
      logic       clk_level;
      logic       dt_level;
      logic       button_level;
      logic [7:0] elapsed_ms;
   } tick_type;

   typedef struct packed {
      enc_result_type enc;
      btn_result_type btn;
   } tick_result_type;

   typedef enum logic {
      ROW_TICK,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      csr_index_type           csr;
      logic [CSR_DATA_W-1:0]   value;
      tick_type                tick;
      logic                    typed;
      tick_result_type         want;
   } stim_row_type;

   localparam tick_result_type NO_RESULT   = '0;
   localparam tick_type        IDLE_LINES  = '0;
   localparam tick_result_type AT_REST     = '{'{ROT_NONE, 32'sd0}, '{BTN_NONE, 1'b0}};
   localparam tick_result_type FIRST_CW    = '{'{ROT_CW, 32'sd1}, '{BTN_NONE, 1'b0}};
   localparam tick_result_type FIRST_PRESS = '{'{ROT_NONE, 32'sd0}, '{BTN_PRESS, 1'b1}};
   localparam tick_result_type BELOW_ZERO  = '{'{ROT_CCW, -32'sd1}, '{BTN_NONE, 1'b1}};
   localparam tick_result_type BUTTON_OFF  = '{'{ROT_NONE, -32'sd1}, '{BTN_NONE, 1'b0}};

   localparam stim_row_type DIRECTED [DIRECTED_LEN] = '{
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b1, 8'd5}, 1'b1, AT_REST},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b1, 1'b1, 8'd5}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b1, 1'b1, 8'd4}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b1, 1'b1, 8'd1}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b0, 1'b1, 8'd10}, 1'b1, FIRST_CW},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b0, 1'b1, 8'd255}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b1, 8'd255}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b1, 1'b0, 8'd3}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b0, 8'd3}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b1, 8'd0}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b0, 8'd10}, 1'b1, FIRST_PRESS},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b1, 8'd9}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b1, 8'd1}, 1'b0, NO_RESULT},
      // Zero debounce: every change is taken on the tick that shows it.
      '{ROW_CSR, CSR_DEBOUNCE_MS, 8'd0, IDLE_LINES, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b0, 1'b1, 8'd0}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b0, 1'b1, 8'd0}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b1, 1'b1, 8'd0}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b0, 1'b0, 8'd0}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b0, 1'b0, 8'd0}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b0, 8'd0}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b0, 1'b0, 8'd0}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b0, 8'd0}, 1'b1, BELOW_ZERO},
      // Button ignored and the longest debounce, so the settle sum nears its top.
      '{ROW_CSR, CSR_BUTTON_ENABLE, 8'd0, IDLE_LINES, 1'b0, NO_RESULT},
      '{ROW_CSR, CSR_DEBOUNCE_MS, 8'd255, IDLE_LINES, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b1, 8'd0}, 1'b1, BUTTON_OFF},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b0, 1'b0, 1'b0, 8'd255}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b1, 8'd254}, 1'b0, NO_RESULT},
      '{ROW_TICK, CSR_DEBOUNCE_MS, 8'd0, '{1'b1, 1'b1, 1'b1, 8'd255}, 1'b0, NO_RESULT},
      '{ROW_CSR, CSR_BUTTON_ENABLE, 8'd1, IDLE_LINES, 1'b0, NO_RESULT}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   redd_req_if req_bus ();
   redd_rsp_if rsp_bus ();

   rotary_encoder_debounced_decoder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Decoder state as the block should hold it, and its settings.
   logic [POSITION_W-1:0] pos_count       = '0;
   logic                  seen_clk        = 1'b1;
   logic                  seen_dt         = 1'b1;
   logic                  seen_button     = 1'b1;
   logic [SETTLE_W-1:0]   enc_hold_ms     = '0;
   logic [SETTLE_W-1:0]   btn_hold_ms     = '0;
   logic [DEBOUNCE_W-1:0] debounce_setting = DEBOUNCE_MS_RESET;
   logic                  button_on       = BUTTON_ENABLE_RESET;

   tick_result_type pending_results [$];
   int unsigned  ticks_sent   = 0;
   int unsigned  mismatches   = 0;
   int unsigned  idle_cycles  = 0;
   int unsigned  ready_hold   = 0;
   bit           send_calm    = 1'b0;
   bit           take_calm    = 1'b0;
   logic         button_goal  = 1'b1;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic tick_result_type decode_tick(input tick_type t);
      tick_result_type r;
      r = '0;
      r.enc.rotation_event = ROT_NONE;
      r.btn.button_event   = BTN_NONE;
      if (t.clk_level != seen_clk || t.dt_level != seen_dt) begin
         enc_hold_ms = enc_hold_ms + {1'b0, t.elapsed_ms};
         if (enc_hold_ms >= {1'b0, debounce_setting}) begin
            // Only a CLK rise that comes with a DT change moves the count.
            if (!seen_clk && t.clk_level && t.dt_level != seen_dt) begin
               if (t.dt_level == seen_clk) begin
                  pos_count = pos_count + 1'b1;
                  r.enc.rotation_event = ROT_CW;
               end else begin
                  pos_count = pos_count - 1'b1;
                  r.enc.rotation_event = ROT_CCW;
               end
            end
            seen_clk    = t.clk_level;
            seen_dt     = t.dt_level;
            enc_hold_ms = '0;
         end
      end else begin
         enc_hold_ms = '0;
      end
      if (button_on) begin
         if (t.button_level != seen_button) begin
            btn_hold_ms = btn_hold_ms + {1'b0, t.elapsed_ms};
            if (btn_hold_ms >= {1'b0, debounce_setting}) begin
               seen_button = t.button_level;
               r.btn.button_event = t.button_level ? BTN_RELEASE : BTN_PRESS;
               btn_hold_ms = '0;
            end
         end else begin
            btn_hold_ms = '0;
         end
         r.btn.button_pressed = !seen_button;
      end else begin
         btn_hold_ms = '0;
      end
      r.enc.position = pos_count;
      return r;
   endfunction

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      if (calm) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   function automatic logic button_sample();
      if ($urandom_range(0, 4) == 0) begin
         return 1'($urandom_range(0, 1));
      end
      return button_goal;
   endfunction

   task automatic send_tick(input tick_type t, input bit typed, input tick_result_type want);
      int unsigned     gap;
      tick_result_type predicted;
      if ($urandom_range(0, 99) == 0) begin
         send_calm = !send_calm;
      end
      gap = pick_gap(send_calm);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.clk_level    <= t.clk_level;
      req_bus.dt_level     <= t.dt_level;
      req_bus.button_level <= t.button_level;
      req_bus.elapsed_ms   <= t.elapsed_ms;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predicted = decode_tick(t);
      pending_results.push_back(typed ? want : predicted);
      ticks_sent++;
   endtask

   // Called in the step of the last accepted beat, or with valid already low, so no beat is sent twice.
   task automatic release_and_drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_MS:   debounce_setting = value;
         CSR_BUTTON_ENABLE: button_on = value[0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input int unsigned n_ticks);
      int unsigned phase_end;
      int unsigned kind;
      int unsigned hold_max;
      int unsigned leg;
      logic        goal_dt;
      tick_type    t;
      phase_end = ticks_sent + n_ticks;
      while (ticks_sent < phase_end) begin
         kind     = $urandom_range(0, 99);
         hold_max = debounce_setting / 3 + 1;
         if ($urandom_range(0, 3) == 0) begin
            button_goal = !button_goal;
         end
         if (kind < 70) begin
            // One detent: settle on a CLK-low pair, then on CLK high with DT flipped.
            goal_dt = 1'($urandom_range(0, 1));
            for (leg = 0; leg < 2; leg++) begin
               if (leg == 1) begin
                  goal_dt = !goal_dt;
               end
               repeat ($urandom_range(0, 2)) begin
                  t = 11'($urandom);
                  t.button_level = button_sample();
                  t.elapsed_ms   = 8'($urandom_range(0, hold_max / 2));
                  send_tick(t, 1'b0, NO_RESULT);
               end
               while (seen_clk !== 1'(leg) || seen_dt !== goal_dt) begin
                  t.clk_level    = 1'(leg);
                  t.dt_level     = goal_dt;
                  t.button_level = button_sample();
                  t.elapsed_ms   = 8'($urandom_range(1, hold_max));
                  send_tick(t, 1'b0, NO_RESULT);
               end
            end
         end else if (kind < 85) begin
            t = 11'($urandom);
            send_tick(t, 1'b0, NO_RESULT);
         end else begin
            // A short glitch, then a return to the levels last accepted.
            t = 11'($urandom);
            if (t.clk_level == seen_clk && t.dt_level == seen_dt) begin
               t.dt_level = !t.dt_level;
            end
            t.elapsed_ms = 8'($urandom_range(0, hold_max / 2));
            send_tick(t, 1'b0, NO_RESULT);
            t.clk_level  = seen_clk;
            t.dt_level   = seen_dt;
            t.elapsed_ms = 8'($urandom);
            send_tick(t, 1'b0, NO_RESULT);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_pacing
      int unsigned stall;
      if ($urandom_range(0, 199) == 0) begin
         take_calm = !take_calm;
      end
      if (ready_hold != 0) begin
         ready_hold    <= ready_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall = pick_gap(take_calm);
         rsp_bus.ready <= (stall == 0);
         ready_hold    <= (stall == 0) ? 0 : stall - 1;
      end
   end

   always @(posedge clock) begin : result_check
      tick_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result beat arrived with no tick outstanding");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.rotation_event !== want.enc.rotation_event) begin
               $error("rotation_event: expected %0d, got %0d",
                      want.enc.rotation_event, rsp_bus.rotation_event);
               mismatches++;
            end
            if (rsp_bus.position !== want.enc.position) begin
               $error("position: expected %0d, got %0d",
                      want.enc.position, rsp_bus.position);
               mismatches++;
            end
            if (rsp_bus.button_event !== want.btn.button_event) begin
               $error("button_event: expected %0d, got %0d",
                      want.btn.button_event, rsp_bus.button_event);
               mismatches++;
            end
            if (rsp_bus.button_pressed !== want.btn.button_pressed) begin
               $error("button_pressed: expected %0d, got %0d",
                      want.btn.button_pressed, rsp_bus.button_pressed);
               mismatches++;
            end
         end
      end
   end

   // Ends a hung run: counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned               row;
      int unsigned               phase;
      logic [CSR_DATA_W-1:0]     debounce_pick;
      logic                      button_pick;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_DEBOUNCE_MS;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.clk_level    <= 1'b1;
      req_bus.dt_level     <= 1'b1;
      req_bus.button_level <= 1'b1;
      req_bus.elapsed_ms   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_LEN; row++) begin
         if (DIRECTED[row].kind == ROW_CSR) begin
            release_and_drain();
            write_csr(DIRECTED[row].csr, DIRECTED[row].value);
         end else begin
            send_tick(DIRECTED[row].tick, DIRECTED[row].typed, DIRECTED[row].want);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin debounce_pick = 8'd10;  button_pick = 1'b1; end
            1: begin debounce_pick = 8'd1;   button_pick = 1'b1; end
            2: begin debounce_pick = 8'd255; button_pick = 1'b1; end
            3: begin debounce_pick = 8'd5;   button_pick = 1'b0; end
            4: begin debounce_pick = 8'd0;   button_pick = 1'b1; end
            5: begin
               debounce_pick = 8'($urandom_range(1, 255));
               button_pick   = 1'($urandom_range(0, 1));
            end
            6: begin debounce_pick = 8'd2;   button_pick = 1'b1; end
            default: begin
               debounce_pick = 8'($urandom_range(1, 40));
               button_pick   = 1'b1;
            end
         endcase
         release_and_drain();
         write_csr(CSR_DEBOUNCE_MS, debounce_pick);
         write_csr(CSR_BUTTON_ENABLE, {{(CSR_DATA_W-1){1'b0}}, button_pick});
         run_phase(PHASE_TICKS);
      end

      release_and_drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
